// ----- hw/rtl/lef_pkg.sv -----
// ----------------------------------------------------------------------------
// lef_pkg
// Shared types and constants of the line editor with erase and kill.
// ----------------------------------------------------------------------------
package lef_pkg;

    localparam int BYTE_W = 8;

    // Configuration register indexes.
    localparam logic [1:0] REG_ERASE     = 2'd0;
    localparam logic [1:0] REG_KILL      = 2'd1;
    localparam logic [1:0] REG_LINE_END  = 2'd2;
    localparam logic [1:0] REG_INPUT_END = 2'd3;

    // Reset values of the editing codes.
    localparam logic [BYTE_W-1:0] ERASE_RST     = 8'd35;
    localparam logic [BYTE_W-1:0] KILL_RST      = 8'd64;
    localparam logic [BYTE_W-1:0] LINE_END_RST  = 8'd10;
    localparam logic [BYTE_W-1:0] INPUT_END_RST = 8'd36;

    // Command kinds passed from the front end to the back end.
    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_ERASE = 2'd1;
    localparam logic [1:0] CMD_KILL  = 2'd2;
    localparam logic [1:0] CMD_CLOSE = 2'd3;

    localparam int CMDQ_DEPTH = 2;
    localparam int OUTQ_DEPTH = 4;

    typedef struct packed {
        logic [1:0]        kind;
        logic [BYTE_W-1:0] data;
        logic              iend;
    } t_cmd;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              ovf;
        logic              iend;
    } t_res;

endpackage

// ----- hw/rtl/lef_ram.sv -----
// ----------------------------------------------------------------------------
// lef_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module lef_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/lef_fifo.sv -----
// ----------------------------------------------------------------------------
// lef_fifo
// Small flip-flop queue with a fill count, used between the pipeline parts.
// ----------------------------------------------------------------------------
module lef_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic [WIDTH-1:0]               i_wdata,
    output logic                           o_full,
    input  logic                           i_pop,
    output logic [WIDTH-1:0]               o_rdata,
    output logic                           o_empty,
    output logic [$clog2(DEPTH+1)-1:0]     o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;
    logic             wr, rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_rdata = r_mem[r_rptr];

    assign wr = i_push && !o_full;
    assign rd = i_pop && !o_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (wr) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (rd) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        case ({wr, rd})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

// ----- hw/rtl/lef_front.sv -----
// ----------------------------------------------------------------------------
// lef_front
// Holds the editing codes, accepts input bytes and classifies each one into
// a command for the back end. Stops forwarding after the input-end byte.
// ----------------------------------------------------------------------------
module lef_front
    import lef_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [BYTE_W-1:0] i_cfg_data,
    input  logic              i_push,
    input  logic [BYTE_W-1:0] i_in_byte,
    input  logic              i_cmd_full,
    output logic              o_cmd_push,
    output t_cmd              o_cmd
);

    logic [BYTE_W-1:0] r_erase_code;
    logic [BYTE_W-1:0] r_kill_code;
    logic [BYTE_W-1:0] r_line_end_code;
    logic [BYTE_W-1:0] r_input_end_code;
    logic              r_finished;
    logic              accept;
    logic              is_iend;
    logic              is_lend;

    assign accept  = i_push && !i_cmd_full;
    assign is_iend = (i_in_byte == r_input_end_code);
    assign is_lend = (i_in_byte == r_line_end_code);

    // Terminators take priority over erase, erase over kill.
    always_comb begin
        o_cmd.data = i_in_byte;
        o_cmd.iend = is_iend;
        if (is_iend || is_lend) begin
            o_cmd.kind = CMD_CLOSE;
        end else if (i_in_byte == r_erase_code) begin
            o_cmd.kind = CMD_ERASE;
        end else if (i_in_byte == r_kill_code) begin
            o_cmd.kind = CMD_KILL;
        end else begin
            o_cmd.kind = CMD_PUSH;
        end
    end

    assign o_cmd_push = accept && !r_finished;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_erase_code     <= ERASE_RST;
            r_kill_code      <= KILL_RST;
            r_line_end_code  <= LINE_END_RST;
            r_input_end_code <= INPUT_END_RST;
            r_finished       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ERASE:     r_erase_code     <= i_cfg_data;
                    REG_KILL:      r_kill_code      <= i_cfg_data;
                    REG_LINE_END:  r_line_end_code  <= i_cfg_data;
                    REG_INPUT_END: r_input_end_code <= i_cfg_data;
                    default:       r_erase_code     <= r_erase_code;
                endcase
            end
            if (o_cmd_push && is_iend) begin
                r_finished <= 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/lef_back.sv -----
// ----------------------------------------------------------------------------
// lef_back
// Executes commands on the line RAM and fill count. A closing command
// drains the buffered bytes through the RAM read port into the output
// queue, then appends the closing item.
// ----------------------------------------------------------------------------
module lef_back
    import lef_pkg::*;
#(
    parameter int LINE_DEPTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic              i_cmd_empty,
    output logic              o_cmd_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output t_res              o_res
);

    localparam int AW  = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CW  = $clog2(LINE_DEPTH + 1);
    localparam int QCW = $clog2(OUTQ_DEPTH + 1);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic              r_state, n_state;
    logic [CW-1:0]     r_fill, n_fill;
    logic [CW-1:0]     r_idx, n_idx;
    logic              r_dropped, n_dropped;
    logic              r_pend;
    logic [BYTE_W-1:0] r_term, n_term;
    logic              r_iend, n_iend;

    logic              ram_we;
    logic [BYTE_W-1:0] ram_rdata;
    logic              rd_issue;
    logic              close_wr;
    logic              oq_wr;
    logic              oq_full;
    logic [QCW-1:0]    oq_cnt;
    t_res              oq_wdata;
    logic              room;

    lef_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (i_cmd.data),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Room counts the read still in flight so the queue never overflows.
    assign room = ({1'b0, oq_cnt} + (QCW+1)'(r_pend)) < (QCW+1)'(OUTQ_DEPTH);

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_idx     = r_idx;
        n_dropped = r_dropped;
        n_term    = r_term;
        n_iend    = r_iend;
        o_cmd_pop = 1'b0;
        ram_we    = 1'b0;
        rd_issue  = 1'b0;
        close_wr  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.kind)
                        CMD_PUSH: begin
                            if (r_fill < CW'(LINE_DEPTH)) begin
                                ram_we = 1'b1;
                                n_fill = r_fill + 1'b1;
                            end else begin
                                n_dropped = 1'b1;
                            end
                        end
                        CMD_ERASE: begin
                            if (r_fill != '0) begin
                                n_fill = r_fill - 1'b1;
                            end
                        end
                        CMD_KILL: begin
                            n_fill = '0;
                        end
                        CMD_CLOSE: begin
                            n_term  = i_cmd.data;
                            n_iend  = i_cmd.iend;
                            n_idx   = '0;
                            n_state = ST_DRAIN;
                        end
                        default: begin
                            n_fill = r_fill;
                        end
                    endcase
                end
            end
            ST_DRAIN: begin
                if (r_idx < r_fill) begin
                    if (room) begin
                        rd_issue = 1'b1;
                        n_idx    = r_idx + 1'b1;
                    end
                end else if (!r_pend && !oq_full) begin
                    close_wr  = 1'b1;
                    n_fill    = '0;
                    n_dropped = 1'b0;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (r_pend) begin
            oq_wdata.data = ram_rdata;
            oq_wdata.last = 1'b0;
            oq_wdata.ovf  = 1'b0;
            oq_wdata.iend = 1'b0;
        end else begin
            oq_wdata.data = r_term;
            oq_wdata.last = 1'b1;
            oq_wdata.ovf  = r_dropped;
            oq_wdata.iend = r_iend;
        end
    end

    assign oq_wr = r_pend || close_wr;

    lef_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (OUTQ_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (oq_wr),
        .i_wdata (oq_wdata),
        .o_full  (oq_full),
        .i_pop   (i_pop),
        .o_rdata (o_res),
        .o_empty (o_empty),
        .o_count (oq_cnt)
    );

    always_ff @(posedge i_clk) begin
        r_term <= n_term;
        r_iend <= n_iend;
        r_idx  <= n_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_fill    <= '0;
            r_dropped <= 1'b0;
            r_pend    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_dropped <= n_dropped;
            r_pend    <= rd_issue;
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(LINE_DEPTH))
        else $error("line fill count exceeds the buffer depth");

    a_no_pop_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> !o_cmd_pop)
        else $error("command taken while a line is draining");

    a_oq_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        oq_wr |-> !oq_full)
        else $error("output queue written while full");

    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        close_wr |=> (r_fill == '0 && !r_dropped && r_state == ST_IDLE))
        else $error("line state not cleared after the closing item");

endmodule

// ----- hw/rtl/line_editor_erase_kill.sv -----
// A byte is applied by the back end in the cycle after acceptance while it is idle.
// A terminator switches the back end to draining: it reads each line byte from the RAM and
// writes it to the output queue, one per cycle while the queue has room, then the closing item.
// The back end either edits or reads a line out, never both, so each byte is stored
// when it arrives and read back at line end.
// Reset (synchronous, active low) restores the codes and clears queues, counts and flags.
// ----------------------------------------------------------------------------
// line_editor_erase_kill
// Line editor with erase and kill codes, built as a classifying front end,
// a command queue and a back end that owns the line buffer.
// ----------------------------------------------------------------------------
module line_editor_erase_kill
    import lef_pkg::*;
#(
    parameter int LINE_DEPTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [BYTE_W-1:0] i_cfg_data,
    input  logic              push,
    output logic              full,
    input  logic [BYTE_W-1:0] i_in_byte,
    output logic              empty,
    input  logic              pop,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_last,
    output logic              o_overflowed,
    output logic              o_input_end
);

    t_cmd                         fe_cmd;
    logic                         fe_push;
    t_cmd                         be_cmd;
    logic                         be_pop;
    logic                         cq_empty;
    logic [$clog2(CMDQ_DEPTH+1)-1:0] cq_count;
    t_res                         res;

    lef_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_push     (push),
        .i_in_byte  (i_in_byte),
        .i_cmd_full (full),
        .o_cmd_push (fe_push),
        .o_cmd      (fe_cmd)
    );

    lef_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMDQ_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_push),
        .i_wdata (fe_cmd),
        .o_full  (full),
        .i_pop   (be_pop),
        .o_rdata (be_cmd),
        .o_empty (cq_empty),
        .o_count (cq_count)
    );

    lef_back #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (be_cmd),
        .i_cmd_empty (cq_empty),
        .o_cmd_pop   (be_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_res       (res)
    );

    assign o_out_byte   = res.data;
    assign o_last       = res.last;
    assign o_overflowed = res.ovf;
    assign o_input_end  = res.iend;

    a_cq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> (cq_count == ($clog2(CMDQ_DEPTH+1))'(CMDQ_DEPTH)))
        else $error("command queue full flag disagrees with its count");

    a_cq_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        be_pop |-> !cq_empty)
        else $error("back end popped an empty command queue");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cq_empty |-> (cq_count == '0))
        else $error("command queue empty flag disagrees with its count");

endmodule
